// ===== rtl/core/b2dasc_pkg.sv =====
`default_nettype none

package b2dasc_pkg;

  // item widths
  localparam int unsigned ValueW   = 32;
  localparam int unsigned DigitsW  = 64;
  localparam int unsigned SigW     = 4;
  localparam int unsigned DigitCnt = 8;
  localparam int unsigned PairCnt  = 4;

  // packed widths on the stream ports
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 72;

  // values below the range limit fit in 27 bits
  localparam logic [31:0] RangeLimit = 32'd100000000;
  localparam int unsigned InW        = 27;

  // floor(x / 10000) = (x * Recip10k) >> Shift10k, exact for x < 2^27
  localparam int unsigned Shift10k = 41;
  localparam logic [27:0] Recip10k = 28'd219902326;
  localparam logic [13:0] Ten4     = 14'd10000;
  localparam int unsigned HalfW    = 14;

  // floor(x / 100) = (x * Recip100) >> Shift100, exact for x < 2^14
  localparam int unsigned Shift100 = 21;
  localparam logic [14:0] Recip100 = 15'd20972;
  localparam logic [6:0]  Ten2     = 7'd100;
  localparam int unsigned PairW    = 7;

  // floor(x / 10) = (x * Recip10) >> Shift10, exact for x < 2^7
  localparam int unsigned Shift10 = 11;
  localparam logic [7:0]  Recip10 = 8'd205;
  localparam logic [3:0]  Ten1    = 4'd10;

  localparam logic [7:0]  AsciiZero = 8'h30;

  typedef logic [PairW-1:0] pair_t;
  typedef logic [3:0]       digit_t;

endpackage

`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii_8digit.sv =====
// six registered stages lie between input accept and output valid
// throughput: one item per cycle while the receiver takes results; each of the six stages holds one item
// and moves on when the stage after it is free, so bubbles close up under stall
// the split runs as three reciprocal multiplies (by 10000, 100, 10), each
// followed by a register and then a multiply-subtract for the remainder
// reset clears the stage valid bits only; data registers are not reset
`default_nettype none

module binary_to_decimal_ascii_8digit
  import b2dasc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,   // [31:0] value
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [OutDataW-1:0] m_axis_tdata,   // [63:0] ascii_digits, [67:64] significant_digits, [71:68] zero
  output      logic                m_axis_tuser    // [0] out_of_range
);

  localparam int unsigned NStg = 6;

  // stage valid bits and load enables
  logic [NStg:1]   vld_q;
  logic [NStg+1:1] open;

  always_comb begin
    open[NStg+1] = m_axis_tready;
    for (int k = NStg; k >= 1; k--) begin
      open[k] = !vld_q[k] || open[k+1];
    end
  end

  assign s_axis_tready = open[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (open[1]) vld_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NStg; k++) begin
        if (open[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // stage 1: range check and reciprocal multiply by 1/10000
  logic [InW-1:0]         v1_q;
  logic                   oor1_q;
  logic [InW+28-1:0]      prod1_q;
  logic [InW+28-1:0]      prod1_d;

  assign prod1_d = (InW+28)'(s_axis_tdata[InW-1:0]) * (InW+28)'(Recip10k);

  always_ff @(posedge clk_i) begin
    if (open[1]) begin
      v1_q    <= s_axis_tdata[InW-1:0];
      oor1_q  <= (s_axis_tdata[ValueW-1:0] >= RangeLimit);
      prod1_q <= prod1_d;
    end
  end

  // stage 2: upper and lower halves of four digits each
  logic [HalfW-1:0] upper2_q, lower2_q, upper2_d, lower2_d;
  logic [InW-1:0]   lowfull2;
  logic             oor2_q;

  assign upper2_d = prod1_q[Shift10k +: HalfW];
  assign lowfull2 = v1_q - InW'(upper2_d) * InW'(Ten4);
  assign lower2_d = lowfull2[HalfW-1:0];

  always_ff @(posedge clk_i) begin
    if (open[2]) begin
      upper2_q <= upper2_d;
      lower2_q <= lower2_d;
      oor2_q   <= oor1_q;
    end
  end

  // stage 3: reciprocal multiply of both halves by 1/100
  logic [HalfW+15-1:0] produ3_q, prodl3_q;
  logic [HalfW-1:0]    upper3_q, lower3_q;
  logic                oor3_q;

  always_ff @(posedge clk_i) begin
    if (open[3]) begin
      produ3_q <= (HalfW+15)'(upper2_q) * (HalfW+15)'(Recip100);
      prodl3_q <= (HalfW+15)'(lower2_q) * (HalfW+15)'(Recip100);
      upper3_q <= upper2_q;
      lower3_q <= lower2_q;
      oor3_q   <= oor2_q;
    end
  end

  // stage 4: four two-digit pairs
  pair_t            pair4_q [PairCnt];
  pair_t            pair4_d [PairCnt];
  logic [HalfW-1:0] remu4, reml4;
  logic             oor4_q;

  always_comb begin
    pair4_d[0] = produ3_q[Shift100 +: PairW];
    pair4_d[2] = prodl3_q[Shift100 +: PairW];
    remu4      = upper3_q - HalfW'(pair4_d[0]) * HalfW'(Ten2);
    reml4      = lower3_q - HalfW'(pair4_d[2]) * HalfW'(Ten2);
    pair4_d[1] = remu4[PairW-1:0];
    pair4_d[3] = reml4[PairW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (open[4]) begin
      pair4_q <= pair4_d;
      oor4_q  <= oor3_q;
    end
  end

  // stage 5: reciprocal multiply of each pair by 1/10
  logic [PairW+8-1:0] prod5_q [PairCnt];
  pair_t              pair5_q [PairCnt];
  logic               oor5_q;

  always_ff @(posedge clk_i) begin
    if (open[5]) begin
      for (int p = 0; p < PairCnt; p++) begin
        prod5_q[p] <= (PairW+8)'(pair4_q[p]) * (PairW+8)'(Recip10);
      end
      pair5_q <= pair4_q;
      oor5_q  <= oor4_q;
    end
  end

  // stage 6: digits, ascii packing and significant digit count
  digit_t             dig [DigitCnt];
  pair_t              rem6 [PairCnt];
  logic [DigitsW-1:0] ascii_d, ascii_q;
  logic [SigW-1:0]    sig_d, sig_q;
  logic               oor6_q;

  always_comb begin
    for (int p = 0; p < PairCnt; p++) begin
      dig[2*p]   = prod5_q[p][Shift10 +: 4];
      rem6[p]    = pair5_q[p] - PairW'(dig[2*p]) * PairW'(Ten1);
      dig[2*p+1] = rem6[p][3:0];
    end
    for (int i = 0; i < DigitCnt; i++) begin
      ascii_d[8*i +: 8] = AsciiZero + 8'(dig[i]);
    end
    // the most significant nonzero digit wins
    sig_d = SigW'(1);
    for (int i = DigitCnt - 1; i >= 0; i--) begin
      if (dig[i] != '0) sig_d = SigW'(DigitCnt - i);
    end
    // out-of-range items carry fixed zero fields
    if (oor5_q) begin
      ascii_d = '0;
      sig_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (open[6]) begin
      ascii_q <= ascii_d;
      sig_q   <= sig_d;
      oor6_q  <= oor5_q;
    end
  end

  // output item
  assign m_axis_tvalid = vld_q[NStg];
  assign m_axis_tdata  = {(OutDataW - DigitsW - SigW)'(0), sig_q, ascii_q};
  assign m_axis_tuser  = oor6_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import b2dasc_pkg::*;

  localparam int unsigned RandomItems = 700;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;

  // one expected conversion, with the value it came from for messages
  typedef struct packed {
    logic [ValueW-1:0]  value;
    logic [DigitsW-1:0] digits;
    logic [SigW-1:0]    sig;
    logic               oor;
  } conversion_t;

  // holds the conversions still owed by the block and checks each result
  class digit_scoreboard;
    conversion_t expected_q[$];
    int unsigned err_count;
    int unsigned in_range_cnt;
    int unsigned oor_cnt;
    int unsigned checked_cnt;

    function void report(string msg);
      err_count++;
      if (err_count <= 30) $display("mismatch: %s", msg);
    endfunction

    // decimal split of one accepted value
    function void note_value(logic [ValueW-1:0] value);
      conversion_t want;
      int unsigned rest;
      int unsigned d;
      want.value  = value;
      want.digits = '0;
      want.sig    = '0;
      want.oor    = 1'b0;
      if (value >= RangeLimit) begin
        // out of range: digits and count are forced to zero
        want.oor = 1'b1;
        oor_cnt++;
      end else begin
        rest = value;
        for (int i = DigitCnt - 1; i >= 0; i--) begin
          d    = rest % 10;
          rest = rest / 10;
          want.digits[8*i +: 8] = AsciiZero + 8'(d);
        end
        // count from the first nonzero digit, zero itself counts as one
        want.sig = 4'd1;
        for (int i = 0; i < DigitCnt; i++) begin
          if (want.digits[8*i +: 8] != AsciiZero) begin
            want.sig = 4'(DigitCnt - i);
            break;
          end
        end
        in_range_cnt++;
      end
      expected_q.push_back(want);
    endfunction

    function void check_result(logic [OutDataW-1:0] data, logic user);
      conversion_t want;
      checked_cnt++;
      if (expected_q.size() == 0) begin
        report($sformatf("item with nothing pending, tdata=%h tuser=%b", data, user));
        return;
      end
      want = expected_q.pop_front();
      if (data[DigitsW-1:0] !== want.digits)
        report($sformatf("value %0d: digits %h, want %h", want.value,
                         data[DigitsW-1:0], want.digits));
      if (data[DigitsW +: SigW] !== want.sig)
        report($sformatf("value %0d: significant %0d, want %0d", want.value,
                         data[DigitsW +: SigW], want.sig));
      if (data[OutDataW-1:DigitsW+SigW] !== '0)
        report($sformatf("value %0d: pad bits %b", want.value,
                         data[OutDataW-1:DigitsW+SigW]));
      if (user !== want.oor)
        report($sformatf("value %0d: out_of_range %b, want %b", want.value,
                         user, want.oor));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  digit_scoreboard sb = new();
  int unsigned     cycle_cnt;

  int unsigned ten_pow [9] = '{1, 10, 100, 1000, 10000, 100000, 1000000,
                               10000000, 100000000};

  binary_to_decimal_ascii_8digit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // note accepted values and check accepted results, sampled at the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_value(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               sb.expected_q.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver stall pattern: picks a new random mode each time the mode age counter wraps
  logic [1:0] stall_mode;
  logic [5:0] mode_age;
  logic [7:0] stall_ring;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      mode_age   <= mode_age + 1;
      stall_ring <= {stall_ring[6:0], stall_ring[7]};
      if (mode_age == '1) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
        2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= stall_ring[0];
      endcase
    end
  end

  // present one value and hold it until the block takes it
  task automatic send_value(input logic [ValueW-1:0] value);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // lower valid for the given number of cycles between bursts
  task automatic sender_gap(input int unsigned cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [ValueW-1:0] directed_vals [$];
    logic [ValueW-1:0] v;
    int unsigned       sent;
    int unsigned       burst_len;
    int unsigned       sel;
    int unsigned       ndig;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cycle_cnt     = 0;
    stall_mode    = 2'd0;
    mode_age      = '0;
    stall_ring    = 8'b1100_1010;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, digit-count edges, range boundary, all-ones
    directed_vals = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
                      32'd1000, 32'd9999, 32'd10000, 32'd100000, 32'd1000000,
                      32'd10000000, 32'd12345678, 32'd87654321, 32'd90909090,
                      32'd99999999, 32'd100000000, 32'd100000001, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF};
    foreach (directed_vals[i]) send_value(directed_vals[i]);
    sender_gap(3);

    // random bursts with random gaps
    sent = 0;
    while (sent < RandomItems) begin
      burst_len = $urandom_range(1, 24);
      for (int k = 0; k < burst_len; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          v = $urandom_range(0, 99999999);
        end else if (sel < 75) begin
          ndig = $urandom_range(1, 8);
          v    = $urandom_range(0, ten_pow[ndig] - 1);
        end else if (sel < 85) begin
          v = (sel < 80) ? 32'd99999999 - $urandom_range(0, 50)
                         : 32'd100000000 + $urandom_range(0, 50);
        end else begin
          v = $urandom();
        end
        send_value(v);
        sent++;
      end
      if ($urandom_range(0, 9) < 7) sender_gap($urandom_range(1, 6));
    end
    sender_gap(1);

    // drain, then allow the pipeline depth for stray items
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    while (sb.expected_q.size() != 0) begin
      sb.report($sformatf("no result for value %0d", sb.expected_q[0].value));
      void'(sb.expected_q.pop_front());
    end

    $display("converted %0d in-range and %0d out-of-range values, %0d results checked",
             sb.in_range_cnt, sb.oor_cnt, sb.checked_cnt);
    $display("%0d cycles, %0d mismatches", cycle_cnt, sb.err_count);
    if (sb.err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
